// File: hdl/ami_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami_pkg
// Widths, types and helpers shared by the affine matrix inverse pipeline.
// ----------------------------------------------------------------------------
package ami_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W_IN      = 32;
    localparam int W_P       = 2 * W_IN;
    localparam int W_C       = W_P + 1;
    localparam int W_H       = W_C - W_IN;
    localparam int W_PP      = W_IN + W_H;
    localparam int W_S       = 3 * W_IN + 2;
    localparam int W_D       = W_S + 1;
    localparam int W_R       = W_D + 1;
    localparam int W_X       = W_S + FRAC_BITS + 2;
    localparam int W_Q       = 32;
    localparam int W_CMP     = (W_X > W_D) ? W_X : W_D;
    localparam int N_ROWS    = 4;

    typedef logic signed [W_IN-1:0] t_in;
    typedef logic signed [W_C-1:0]  t_cof;
    typedef logic signed [W_PP-1:0] t_pp;
    typedef logic signed [W_S-1:0]  t_sum;
    typedef logic [1:0]             t_row;

    localparam t_row ROW_TRANS = 2'd3;
    localparam t_row ROW_FIRST = 2'd0;

    localparam logic [W_Q-1:0] Q_MAX = {1'b0, {(W_Q-1){1'b1}}};
    localparam logic [W_Q-1:0] Q_MIN = {1'b1, {(W_Q-1){1'b0}}};

    typedef struct packed {
        t_row row;
        logic last;
        logic sing;
    } t_meta;

    typedef struct packed {
        logic [2:0][W_X-1:0] x;
        logic [2:0]          neg;
        logic [W_D-1:0]      d2;
        t_meta               meta;
    } t_div_in;

    typedef struct packed {
        logic                v;
        logic [2:0][W_X-1:0] r;
        logic [2:0][W_Q-1:0] q;
        logic [2:0]          neg;
        logic [2:0]          ovf;
        logic [W_D-1:0]      d2;
        t_meta               meta;
    } t_div_st;

    // rebuild m * c from its high and low partial products
    function automatic t_sum pp_join(input t_pp hi, input t_pp lo);
        return (t_sum'(hi) <<< W_IN) + t_sum'(lo);
    endfunction

endpackage

// File: hdl/ami_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami_cof
// Two stages: the eighteen 32x32 cofactor products, then the nine cofactors.
// ----------------------------------------------------------------------------
module ami_cof (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  ami_pkg::t_in i_m  [3][3],
    input  ami_pkg::t_in i_t  [3],
    output logic         o_valid,
    output ami_pkg::t_cof o_c [3][3],
    output ami_pkg::t_in o_m0 [3],
    output ami_pkg::t_in o_t  [3]
);

    logic                           r_v1;
    logic signed [ami_pkg::W_P-1:0] r_p1 [3][3];
    logic signed [ami_pkg::W_P-1:0] r_p2 [3][3];
    ami_pkg::t_in                   r_m0 [3];
    ami_pkg::t_in                   r_t  [3];
    logic                           r_v2;
    ami_pkg::t_cof                  r_c  [3][3];
    ami_pkg::t_in                   r_m0b [3];
    ami_pkg::t_in                   r_tb  [3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            always_ff @(posedge i_clk) begin
                r_p1[gi][gj] <= i_m[J1][I1] * i_m[J2][I2];
                r_p2[gi][gj] <= i_m[J1][I2] * i_m[J2][I1];
                r_c[gi][gj]  <= ami_pkg::t_cof'(r_p1[gi][gj])
                              - ami_pkg::t_cof'(r_p2[gi][gj]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m0[k]  <= i_m[0][k];
            r_t[k]   <= i_t[k];
            r_m0b[k] <= r_m0[k];
            r_tb[k]  <= r_t[k];
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_c     = r_c;
    assign o_m0    = r_m0b;
    assign o_t     = r_tb;

endmodule

// File: hdl/ami_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami_det
// Three stages: split 32x65 partial products, determinant and translation
// dot products, then magnitudes and signs.
// ----------------------------------------------------------------------------
module ami_det (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  ami_pkg::t_cof            i_c  [3][3],
    input  ami_pkg::t_in             i_m0 [3],
    input  ami_pkg::t_in             i_t  [3],
    output logic                     o_valid,
    output logic [ami_pkg::W_S-1:0]  o_dmag,
    output logic                     o_dneg,
    output logic                     o_dzero,
    output logic [ami_pkg::W_S-1:0]  o_smag [3],
    output logic                     o_sneg [3],
    output logic [ami_pkg::W_C-1:0]  o_cmag [3][3],
    output logic                     o_cneg [3][3]
);

    logic                          r_v3, r_v4, r_v5;
    ami_pkg::t_pp                  r_dl [3];
    ami_pkg::t_pp                  r_dh [3];
    ami_pkg::t_pp                  r_tl [3][3];
    ami_pkg::t_pp                  r_th [3][3];
    logic [ami_pkg::W_C-1:0]       r_cm3 [3][3];
    logic                          r_cn3 [3][3];
    ami_pkg::t_sum                 r_det;
    ami_pkg::t_sum                 r_s [3];
    logic [ami_pkg::W_C-1:0]       r_cm4 [3][3];
    logic                          r_cn4 [3][3];
    logic [ami_pkg::W_S-1:0]       r_dmag;
    logic                          r_dneg;
    logic                          r_dzero;
    logic [ami_pkg::W_S-1:0]       r_smag [3];
    logic                          r_sneg [3];
    logic [ami_pkg::W_C-1:0]       r_cm5 [3][3];
    logic                          r_cn5 [3][3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dl[k] <= i_m0[k] * $signed({1'b0, i_c[k][0][ami_pkg::W_IN-1:0]});
            r_dh[k] <= i_m0[k] * $signed(i_c[k][0][ami_pkg::W_C-1:ami_pkg::W_IN]);
            for (int j = 0; j < 3; j++) begin
                r_tl[k][j] <= i_t[k] * $signed({1'b0, i_c[k][j][ami_pkg::W_IN-1:0]});
                r_th[k][j] <= i_t[k] * $signed(i_c[k][j][ami_pkg::W_C-1:ami_pkg::W_IN]);
                r_cm3[k][j] <= i_c[k][j][ami_pkg::W_C-1] ? -i_c[k][j] : i_c[k][j];
                r_cn3[k][j] <= i_c[k][j][ami_pkg::W_C-1];
            end
        end

        r_det <= ami_pkg::pp_join(r_dh[0], r_dl[0]) + ami_pkg::pp_join(r_dh[1], r_dl[1])
               + ami_pkg::pp_join(r_dh[2], r_dl[2]);
        for (int j = 0; j < 3; j++) begin
            r_s[j] <= ami_pkg::pp_join(r_th[0][j], r_tl[0][j])
                    + ami_pkg::pp_join(r_th[1][j], r_tl[1][j])
                    + ami_pkg::pp_join(r_th[2][j], r_tl[2][j]);
        end
        r_cm4 <= r_cm3;
        r_cn4 <= r_cn3;

        r_dmag  <= r_det[ami_pkg::W_S-1] ? -r_det : r_det;
        r_dneg  <= r_det[ami_pkg::W_S-1];
        r_dzero <= (r_det == '0);
        for (int j = 0; j < 3; j++) begin
            r_smag[j] <= r_s[j][ami_pkg::W_S-1] ? -r_s[j] : r_s[j];
            r_sneg[j] <= r_s[j][ami_pkg::W_S-1];
        end
        r_cm5 <= r_cm4;
        r_cn5 <= r_cn4;

        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_valid = r_v5;
    assign o_dmag  = r_dmag;
    assign o_dneg  = r_dneg;
    assign o_dzero = r_dzero;
    assign o_smag  = r_smag;
    assign o_sneg  = r_sneg;
    assign o_cmag  = r_cm5;
    assign o_cneg  = r_cn5;

endmodule

// File: hdl/ami_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami_row
// Holds one item and issues its four result rows, one per cycle, as
// scaled dividends and doubled divisor for the divider.
// ----------------------------------------------------------------------------
module ami_row (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [ami_pkg::W_S-1:0]  i_dmag,
    input  logic                     i_dneg,
    input  logic                     i_dzero,
    input  logic [ami_pkg::W_S-1:0]  i_smag [3],
    input  logic                     i_sneg [3],
    input  logic [ami_pkg::W_C-1:0]  i_cmag [3][3],
    input  logic                     i_cneg [3][3],
    output logic                     o_valid,
    output ami_pkg::t_div_in         o_d
);

    logic [ami_pkg::W_S-1:0] r_dmag;
    logic                    r_dneg;
    logic                    r_dzero;
    logic [ami_pkg::W_S-1:0] r_smag [3];
    logic                    r_sneg [3];
    logic [ami_pkg::W_C-1:0] r_cmag [3][3];
    logic                    r_cneg [3][3];
    ami_pkg::t_row           r_cnt;
    logic                    r_act;
    logic                    r_ov;
    ami_pkg::t_div_in        r_d;
    ami_pkg::t_div_in        n_d;

    always_comb begin
        logic [ami_pkg::W_X-1:0] v_mag;
        n_d.meta.row  = r_cnt;
        n_d.meta.last = (r_cnt == ami_pkg::ROW_TRANS);
        n_d.meta.sing = r_dzero;
        n_d.d2        = ami_pkg::W_D'(r_dmag) << 1;
        for (int j = 0; j < 3; j++) begin
            if (r_cnt == ami_pkg::ROW_TRANS) begin
                v_mag      = ami_pkg::W_X'(r_smag[j]) << (ami_pkg::FRAC_BITS + 1);
                n_d.neg[j] = ~r_sneg[j] ^ r_dneg;
            end else begin
                v_mag      = ami_pkg::W_X'(r_cmag[r_cnt][j]) << (2 * ami_pkg::FRAC_BITS + 1);
                n_d.neg[j] = r_cneg[r_cnt][j] ^ r_dneg;
            end
            n_d.x[j] = v_mag + ami_pkg::W_X'(r_dmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_dmag  <= i_dmag;
            r_dneg  <= i_dneg;
            r_dzero <= i_dzero;
            r_smag  <= i_smag;
            r_sneg  <= i_sneg;
            r_cmag  <= i_cmag;
            r_cneg  <= i_cneg;
        end
        r_d <= n_d;
        if (!i_rst_n) begin
            r_cnt <= ami_pkg::ROW_FIRST;
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_ov <= r_act;
            if (i_valid) begin
                r_cnt <= ami_pkg::ROW_FIRST;
                r_act <= 1'b1;
            end else if (r_act) begin
                r_cnt <= r_cnt + 2'd1;
                r_act <= (r_cnt != ami_pkg::ROW_TRANS);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_d     = r_d;

endmodule

// File: hdl/ami_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami_div
// Pipelined restoring divider, one quotient bit per stage, three columns
// sharing one divisor. Rounds via the doubled divisor, then saturates.
// ----------------------------------------------------------------------------
module ami_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  ami_pkg::t_div_in         i_d,
    output logic                     o_valid,
    output ami_pkg::t_row            o_row_index,
    output logic [ami_pkg::W_Q-1:0]  o_col [3],
    output logic                     o_last_row,
    output logic                     o_singular
);

    ami_pkg::t_div_st        r_st [ami_pkg::W_Q+1];
    ami_pkg::t_div_st        n_st [ami_pkg::W_Q+1];
    logic                    r_ov;
    ami_pkg::t_meta          r_meta;
    logic [ami_pkg::W_Q-1:0] r_col [3];

    always_comb begin
        n_st[0].v    = i_valid;
        n_st[0].r    = i_d.x;
        n_st[0].q    = '0;
        n_st[0].neg  = i_d.neg;
        n_st[0].d2   = i_d.d2;
        n_st[0].meta = i_d.meta;
        for (int j = 0; j < 3; j++) begin
            n_st[0].ovf[j] = ami_pkg::W_CMP'(i_d.x[j] >> ami_pkg::W_Q)
                          >= ami_pkg::W_CMP'(i_d.d2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0] <= '0;
        end else begin
            r_st[0] <= n_st[0];
        end
    end

    for (genvar k = 0; k < ami_pkg::W_Q; k++) begin : g_stage
        localparam int BIT = ami_pkg::W_Q - 1 - k;
        always_comb begin
            n_st[k+1] = r_st[k];
            for (int j = 0; j < 3; j++) begin
                if (ami_pkg::W_R'(r_st[k].r[j] >> BIT) >= {1'b0, r_st[k].d2}) begin
                    n_st[k+1].r[j]      = r_st[k].r[j] - (ami_pkg::W_X'(r_st[k].d2) << BIT);
                    n_st[k+1].q[j][BIT] = 1'b1;
                end else begin
                    n_st[k+1].q[j][BIT] = 1'b0;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1] <= '0;
            end else begin
                r_st[k+1] <= n_st[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= r_st[ami_pkg::W_Q].meta;
        for (int j = 0; j < 3; j++) begin
            if (r_st[ami_pkg::W_Q].meta.sing) begin
                r_col[j] <= '0;
            end else if (r_st[ami_pkg::W_Q].neg[j]) begin
                r_col[j] <= (r_st[ami_pkg::W_Q].ovf[j] || r_st[ami_pkg::W_Q].q[j][ami_pkg::W_Q-1])
                          ? ami_pkg::Q_MIN : -r_st[ami_pkg::W_Q].q[j];
            end else begin
                r_col[j] <= (r_st[ami_pkg::W_Q].ovf[j] || r_st[ami_pkg::W_Q].q[j][ami_pkg::W_Q-1])
                          ? ami_pkg::Q_MAX : r_st[ami_pkg::W_Q].q[j];
            end
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_st[ami_pkg::W_Q].v;
        end
    end

    assign o_valid     = r_ov;
    assign o_row_index = r_meta.row;
    assign o_last_row  = r_meta.last;
    assign o_singular  = r_meta.sing;
    assign o_col       = r_col;

endmodule

// File: hdl/affine_matrix_inverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_top
// Inverse of a row-vector affine transform (3x3 linear part plus
// translation row) in signed Q16.16, by cofactors over the determinant.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while r_gap counts down, spacing items to match the four result rows that
// each item puts on the single result port. Each item gives rows 0, 1, 2 of
// the inverse and then the inverse translation row (marked by o_last_row)
// back to back, each flagged by o_valid for one cycle. Each row passes the
// 32-stage quotient pipeline behind the cofactor and determinant stages.
// Results cannot be held off: the receiver must take each row in the cycle
// that o_valid is high. A zero determinant gives o_singular and zero
// columns on all four rows.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_r0c0,
    input  logic [31:0] i_r0c1,
    input  logic [31:0] i_r0c2,
    input  logic [31:0] i_r1c0,
    input  logic [31:0] i_r1c1,
    input  logic [31:0] i_r1c2,
    input  logic [31:0] i_r2c0,
    input  logic [31:0] i_r2c1,
    input  logic [31:0] i_r2c2,
    input  logic [31:0] i_tx,
    input  logic [31:0] i_ty,
    input  logic [31:0] i_tz,
    output logic        o_valid,
    output logic [1:0]  o_row_index,
    output logic [31:0] o_col0,
    output logic [31:0] o_col1,
    output logic [31:0] o_col2,
    output logic        o_last_row,
    output logic        o_singular
);

    logic [1:0]                r_gap;
    logic                      w_acc;
    ami_pkg::t_in              w_m [3][3];
    ami_pkg::t_in              w_t [3];

    logic                      w_cof_v;
    ami_pkg::t_cof             w_c  [3][3];
    ami_pkg::t_in              w_m0 [3];
    ami_pkg::t_in              w_tc [3];

    logic                      w_det_v;
    logic [ami_pkg::W_S-1:0]   w_dmag;
    logic                      w_dneg;
    logic                      w_dzero;
    logic [ami_pkg::W_S-1:0]   w_smag [3];
    logic                      w_sneg [3];
    logic [ami_pkg::W_C-1:0]   w_cmag [3][3];
    logic                      w_cneg [3][3];

    logic                      w_row_v;
    ami_pkg::t_div_in          w_div_d;
    logic [ami_pkg::W_Q-1:0]   w_col [3];

    assign w_acc = start && !busy;
    assign busy  = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (w_acc) begin
            r_gap <= 2'(ami_pkg::N_ROWS - 1);
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    always_comb begin
        w_m[0][0] = i_r0c0;
        w_m[0][1] = i_r0c1;
        w_m[0][2] = i_r0c2;
        w_m[1][0] = i_r1c0;
        w_m[1][1] = i_r1c1;
        w_m[1][2] = i_r1c2;
        w_m[2][0] = i_r2c0;
        w_m[2][1] = i_r2c1;
        w_m[2][2] = i_r2c2;
        w_t[0]    = i_tx;
        w_t[1]    = i_ty;
        w_t[2]    = i_tz;
    end

    ami_cof u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_m     (w_m),
        .i_t     (w_t),
        .o_valid (w_cof_v),
        .o_c     (w_c),
        .o_m0    (w_m0),
        .o_t     (w_tc)
    );

    ami_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cof_v),
        .i_c     (w_c),
        .i_m0    (w_m0),
        .i_t     (w_tc),
        .o_valid (w_det_v),
        .o_dmag  (w_dmag),
        .o_dneg  (w_dneg),
        .o_dzero (w_dzero),
        .o_smag  (w_smag),
        .o_sneg  (w_sneg),
        .o_cmag  (w_cmag),
        .o_cneg  (w_cneg)
    );

    ami_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_det_v),
        .i_dmag  (w_dmag),
        .i_dneg  (w_dneg),
        .i_dzero (w_dzero),
        .i_smag  (w_smag),
        .i_sneg  (w_sneg),
        .i_cmag  (w_cmag),
        .i_cneg  (w_cneg),
        .o_valid (w_row_v),
        .o_d     (w_div_d)
    );

    ami_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_row_v),
        .i_d         (w_div_d),
        .o_valid     (o_valid),
        .o_row_index (o_row_index),
        .o_col       (w_col),
        .o_last_row  (o_last_row),
        .o_singular  (o_singular)
    );

    assign o_col0 = w_col[0];
    assign o_col1 = w_col[1];
    assign o_col2 = w_col[2];

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> busy)
        else $error("busy not raised after an item was taken");

    a_last_is_trans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == ami_pkg::ROW_TRANS)))
        else $error("last-row mark out of step with row index");

    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_row_index != ami_pkg::ROW_FIRST)) |->
            ($past(o_valid) && ($past(o_row_index) == o_row_index - 2'd1)))
        else $error("result rows of an item not back to back");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> ((o_col0 == '0) && (o_col1 == '0) && (o_col2 == '0)))
        else $error("nonzero column on a singular item");

endmodule

// File: tb/affine_matrix_inverse_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_top_tb
// Drives 3x3-plus-translation items into the affine inverse block and
// checks every result row against an exact wide-integer cofactor
// predictor (rounding, saturation, singular handling).
// ----------------------------------------------------------------------------
module affine_matrix_inverse_top_tb;

    typedef logic signed [159:0] t_wide;

    typedef struct {
        ami_pkg::t_row row;
        logic [31:0]   col [3];
        logic          last;
        logic          sing;
    } t_inv_row;

    class inverse_scoreboard;
        t_inv_row rows_due [$];
        int       errors;
        int       rows_seen;
        int       singular_items;

        function t_wide sx(logic [31:0] v);
            return t_wide'(signed'(v));
        endfunction

        function logic [31:0] quot_sat(t_wide num, t_wide den);
            logic  negative;
            t_wide an, ad, q;
            negative = (num < 0) != (den < 0);
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q  = ((an <<< 1) + ad) / (ad <<< 1);
            if (negative) begin
                if (q > t_wide'(64'h8000_0000)) return ami_pkg::Q_MIN;
                return 32'(-q);
            end
            if (q > t_wide'(64'h7FFF_FFFF)) return ami_pkg::Q_MAX;
            return q[31:0];
        endfunction

        function void note_item(logic [31:0] f [12]);
            t_wide    m [3][3], t [3], c [3][3], det, num, s;
            t_inv_row r;
            int       i1, i2, j1, j2;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) m[i][j] = sx(f[i*3+j]);
                t[i] = sx(f[9+i]);
            end
            for (int i = 0; i < 3; i++) begin
                i1 = (i + 1) % 3;
                i2 = (i + 2) % 3;
                for (int j = 0; j < 3; j++) begin
                    j1 = (j + 1) % 3;
                    j2 = (j + 2) % 3;
                    c[i][j] = m[j1][i1] * m[j2][i2] - m[j1][i2] * m[j2][i1];
                end
            end
            det = m[0][0] * c[0][0] + m[0][1] * c[1][0] + m[0][2] * c[2][0];
            if (det == 0) singular_items++;
            for (int i = 0; i < ami_pkg::N_ROWS; i++) begin
                r.row  = ami_pkg::t_row'(i);
                r.last = (r.row == ami_pkg::ROW_TRANS);
                r.sing = (det == 0);
                for (int j = 0; j < 3; j++) begin
                    if (det == 0) begin
                        r.col[j] = '0;
                    end else begin
                        if (r.row != ami_pkg::ROW_TRANS) begin
                            num = c[i][j] <<< (2 * ami_pkg::FRAC_BITS);
                        end else begin
                            s = 0;
                            for (int k = 0; k < 3; k++) s += t[k] * c[k][j];
                            num = -(s <<< ami_pkg::FRAC_BITS);
                        end
                        r.col[j] = quot_sat(num, det);
                    end
                end
                rows_due.push_back(r);
            end
        endfunction

        function void check_row(ami_pkg::t_row row, logic [31:0] c0, logic [31:0] c1,
                                logic [31:0] c2, logic last, logic sing);
            t_inv_row e;
            logic [31:0] got [3];
            rows_seen++;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row %0d", $time, row);
                errors++;
                return;
            end
            e = rows_due.pop_front();
            got[0] = c0;
            got[1] = c1;
            got[2] = c2;
            if (row !== e.row) begin
                $display("%0t: row_index exp %0d got %0d", $time, e.row, row);
                errors++;
            end
            for (int j = 0; j < 3; j++)
                if (got[j] !== e.col[j]) begin
                    $display("%0t: row %0d col%0d exp %h got %h",
                             $time, e.row, j, e.col[j], got[j]);
                    errors++;
                end
            if (last !== e.last) begin
                $display("%0t: last_row exp %b got %b", $time, e.last, last);
                errors++;
            end
            if (sing !== e.sing) begin
                $display("%0t: singular exp %b got %b", $time, e.sing, sing);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] fld [12];
    logic        o_valid;
    logic [1:0]  o_row_index;
    logic [31:0] o_col0, o_col1, o_col2;
    logic        o_last_row, o_singular;

    inverse_scoreboard sb = new();
    int items_sent;

    initial for (int k = 0; k < 12; k++) fld[k] = '0;

    always #10 i_clk = ~i_clk;

    affine_matrix_inverse_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_r0c0(fld[0]), .i_r0c1(fld[1]), .i_r0c2(fld[2]),
        .i_r1c0(fld[3]), .i_r1c1(fld[4]), .i_r1c2(fld[5]),
        .i_r2c0(fld[6]), .i_r2c1(fld[7]), .i_r2c2(fld[8]),
        .i_tx(fld[9]), .i_ty(fld[10]), .i_tz(fld[11]),
        .o_valid(o_valid), .o_row_index(o_row_index),
        .o_col0(o_col0), .o_col1(o_col1), .o_col2(o_col2),
        .o_last_row(o_last_row), .o_singular(o_singular)
    );

    always @(posedge i_clk)
        if (i_rst_n && o_valid)
            sb.check_row(o_row_index, o_col0, o_col1, o_col2, o_last_row, o_singular);

    // called just after a falling edge; returns just after the accepting edge's fall
    task automatic send_item(logic [31:0] v [12], bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        for (int k = 0; k < 12; k++) fld[k] = v[k];
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_item(v);
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (sb.rows_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] fix_near(int lo, int hi);
        return 32'($signed($urandom_range(0, hi - lo)) + lo);
    endfunction

    task automatic random_item(bit idle_ok);
        logic [31:0] v [12];
        int kind;
        int src;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++) v[k] = $urandom;
        if (kind < 5) begin
            // well-conditioned: diagonal near 2, -2 and 3, modest off-diagonal
            for (int k = 0; k < 9; k++) v[k] = fix_near(-40000, 40000);
            v[0] += 32'h0002_0000;
            v[4] -= 32'h0002_0000;
            v[8] += 32'h0003_0000;
            for (int k = 9; k < 12; k++)
                if ($urandom_range(0, 1)) v[k] = fix_near(-9000000, 9000000);
        end else if (kind == 6) begin
            // repeated row: singular
            src = 3 * $urandom_range(0, 1);
            for (int k = 0; k < 3; k++) v[6+k] = v[src+k];
        end else if (kind == 7) begin
            for (int k = 0; k < 9; k++) v[k] = fix_near(-3, 3);
        end else if (kind == 8) begin
            for (int k = 0; k < 9; k++) v[k] = fix_near(-300, 300) <<< 16;
        end
        send_item(v, idle_ok);
    endtask

    initial begin
        logic [31:0] v [12];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // identity with translation
        for (int k = 0; k < 12; k++) v[k] = '0;
        v[0] = 32'h0001_0000; v[4] = 32'h0001_0000; v[8] = 32'h0001_0000;
        v[9] = 32'h0003_8000; v[10] = 32'hFFFE_0000; v[11] = 32'h7FFF_FFFF;
        send_item(v, 0);
        // all zero
        for (int k = 0; k < 12; k++) v[k] = '0;
        send_item(v, 0);
        // all max, all min
        for (int k = 0; k < 12; k++) v[k] = ami_pkg::Q_MAX;
        send_item(v, 0);
        for (int k = 0; k < 12; k++) v[k] = ami_pkg::Q_MIN;
        send_item(v, 0);
        // diagonal extremes: tiny and huge scale, saturating results
        for (int k = 0; k < 12; k++) v[k] = '0;
        v[0] = 32'd1; v[4] = 32'd1; v[8] = 32'd1;
        v[9] = ami_pkg::Q_MIN; v[10] = ami_pkg::Q_MAX;
        send_item(v, 0);
        v[0] = ami_pkg::Q_MIN; v[4] = ami_pkg::Q_MAX; v[8] = ami_pkg::Q_MIN;
        v[9] = ami_pkg::Q_MAX; v[10] = 32'd1; v[11] = ami_pkg::Q_MIN;
        send_item(v, 0);
        // diagonal of -1, 2 and 3, half-step ties
        for (int k = 0; k < 12; k++) v[k] = '0;
        v[0] = 32'hFFFF_0000; v[4] = 32'h0002_0000; v[8] = 32'h0003_0000;
        v[9] = 32'd1; v[10] = 32'hFFFF_FFFF; v[11] = 32'd3;
        send_item(v, 0);
        // signed permutation matrix, zero row
        for (int k = 0; k < 12; k++) v[k] = '0;
        v[1] = 32'h0001_0000; v[5] = 32'hFFFF_0000; v[6] = 32'h0001_0000;
        v[9] = 32'h1234_5678;
        send_item(v, 0);
        v[1] = '0; v[5] = '0; v[6] = '0; v[0] = 32'h0001_0000; v[4] = 32'h0001_0000;
        send_item(v, 0);
        // alternating bit patterns
        for (int k = 0; k < 12; k++) v[k] = (k % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
        send_item(v, 0);
        for (int k = 0; k < 12; k++) v[k] = (k % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
        send_item(v, 0);

        for (int n = 0; n < 470; n++) begin
            if (n == 200) begin
                start = 1'b0;
                drain();
                @(negedge i_clk);
            end
            random_item(n < 400);
        end

        start = 1'b0;
        drain();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d items (%0d singular), checked %0d result rows.",
                 items_sent, sb.singular_items, sb.rows_seen);
        if (sb.errors == 0 && sb.rows_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(20 * 400000);
        $display("Timeout with %0d rows outstanding", sb.rows_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
hdl/ami_pkg.sv
hdl/ami_cof.sv
hdl/ami_det.sv
hdl/ami_row.sv
hdl/ami_div.sv
hdl/affine_matrix_inverse_top.sv
tb/affine_matrix_inverse_top_tb.sv
